### sv/top_ten_score_table_assert.svh
// Assertion macros for the top-ten score table.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef TOP_TEN_SCORE_TABLE_ASSERT_SVH
`define TOP_TEN_SCORE_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

`define TTS_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("top_ten_score_table: invariant violated");

`define TTS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("top_ten_score_table: implication violated");

`define TTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("top_ten_score_table: next-cycle check violated");

`else

`define TTS_ASSERT_ALWAYS(label, expr)
`define TTS_ASSERT_IMP(label, ante, cons)
`define TTS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### sv/tts_pkg.sv
`timescale 1ns / 1ps
package tts_pkg;

    localparam int DEPTH_DEFAULT    = 10;
    localparam int TAG_BITS_DEFAULT = 64;

    localparam int REQ_W       = 2;
    localparam int SCORE_W     = 8;
    localparam int IDX_W       = 4;
    localparam int STATUS_W    = 2;
    localparam int RANK_OUT_W  = 4;
    localparam int LAST_RANK_W = 5;
    localparam int CFG_INDEX_W = 1;

    localparam logic [63:0] EMPTY_TAG_RESET       = 64'h0000_0000_002D_2D2D;
    localparam logic [63:0] PLACEHOLDER_TAG_RESET = 64'h0;

    typedef enum logic [REQ_W-1:0] {
        REQ_SUBMIT = 2'd0,
        REQ_RENAME = 2'd1,
        REQ_READ   = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_LOW_SCORE = 2'd1,
        STATUS_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PLACEHOLDER_TAG = 1'b0,
        CFG_EMPTY_TAG       = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    typedef struct packed {
        logic insert;
        logic rename;
        logic clear;
        logic rotate;
    } cell_ctl_t;

endpackage

### sv/tts_if.sv
`timescale 1ns / 1ps
interface tts_req_if #(
    parameter int TAG_BITS = tts_pkg::TAG_BITS_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic [tts_pkg::REQ_W-1:0]     req_type;
    logic                          list_select;
    logic [tts_pkg::SCORE_W-1:0]   new_score;
    logic [tts_pkg::IDX_W-1:0]     rank_index;
    logic [TAG_BITS-1:0]           name_tag;

    modport source (
        output valid, req_type, list_select, new_score, rank_index, name_tag,
        input  ready
    );
    modport sink (
        input  valid, req_type, list_select, new_score, rank_index, name_tag,
        output ready
    );
endinterface

interface tts_rsp_if #(
    parameter int TAG_BITS = tts_pkg::TAG_BITS_DEFAULT
);
    logic                                   valid;
    logic                                   ready;
    logic [tts_pkg::STATUS_W-1:0]           status;
    logic [tts_pkg::RANK_OUT_W-1:0]         entry_rank;
    logic [tts_pkg::SCORE_W-1:0]            entry_score;
    logic [TAG_BITS-1:0]                    entry_tag;
    logic signed [tts_pkg::LAST_RANK_W-1:0] last_new_rank;
    logic                                   last_of_run;

    modport source (
        output valid, status, entry_rank, entry_score, entry_tag, last_new_rank,
               last_of_run,
        input  ready
    );
    modport sink (
        input  valid, status, entry_rank, entry_score, entry_tag, last_new_rank,
               last_of_run,
        output ready
    );
endinterface

### sv/top_ten_score_table.sv
`timescale 1ns / 1ps
// Two descending top-ten tables (dynamic and fixed-time) of score and name tag,
// each held in a chain of TABLE_DEPTH cells. Submit, rename and clear are
// accepted when ready and each gives one item; a submit compares the score in
// every cell at once and the chain shifts lower entries down in the cycle it is
// accepted. A read gives TABLE_DEPTH items, one per cycle while the output is
// taken: the chosen table rotates one place past cell 0 for each item, and no
// new item is accepted until the last read item is in the output register. The
// next item is taken while a finished item waits in the one-entry output
// register only if that item leaves this cycle. Tables come out of reset at
// zero scores and the empty tag; no clearing pass.
`include "top_ten_score_table_assert.svh"
module top_ten_score_table #(
    parameter int TABLE_DEPTH = tts_pkg::DEPTH_DEFAULT,
    parameter int TAG_BITS    = tts_pkg::TAG_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tts_req_if.sink                         req,
    tts_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [tts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [TAG_BITS-1:0]             cfg_data
);
    import tts_pkg::*;

    localparam int RANK_W = $clog2(TABLE_DEPTH);
    localparam int NUM_TABLES = 2;

    // table 0 is the dynamic list, table 1 the fixed-time list
    logic [SCORE_W-1:0]     score_w [NUM_TABLES][TABLE_DEPTH];
    logic [TAG_BITS-1:0]    tag_w   [NUM_TABLES][TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] gt_w    [NUM_TABLES];
    logic [TABLE_DEPTH-1:0] pos_w   [NUM_TABLES];
    cell_ctl_t              ctl_w   [NUM_TABLES];
    logic [TAG_BITS-1:0]    data_tag;

    logic [TAG_BITS-1:0]           placeholder_tag_reg;
    logic [TAG_BITS-1:0]           empty_tag_reg;
    state_t                        state_reg, state_next;
    logic [RANK_W-1:0]             cnt_reg, cnt_next;
    logic                          read_sel_reg, read_sel_next;
    logic signed [LAST_RANK_W-1:0] latest_rank_reg, latest_rank_next;

    logic                          out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]           out_status_reg, out_status_next;
    logic [RANK_OUT_W-1:0]         out_rank_reg, out_rank_next;
    logic [SCORE_W-1:0]            out_score_reg, out_score_next;
    logic [TAG_BITS-1:0]           out_tag_reg, out_tag_next;
    logic signed [LAST_RANK_W-1:0] out_last_rank_reg, out_last_rank_next;
    logic                          out_last_reg, out_last_next;

    logic              out_free;
    logic              accept;
    logic              ins_ok;
    logic [RANK_W-1:0] ins_rank;
    logic              idx_ok;

    for (genvar t = 0; t < NUM_TABLES; t++)
    begin : g_tbl
        for (genvar i = 0; i < TABLE_DEPTH; i++)
        begin : g_cell
            localparam int PI = (i == 0) ? 0 : i - 1;
            localparam int NI = (i == TABLE_DEPTH - 1) ? 0 : i + 1;

            tts_cell #(
                .TAG_BITS (TAG_BITS),
                .IDX      (i)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl_w[t]),
                .new_score  (req.new_score),
                .rank_index (req.rank_index),
                .data_tag   (data_tag),
                .prev_gt    ((i == 0) ? 1'b0 : gt_w[t][PI]),
                .prev_score (score_w[t][PI]),
                .prev_tag   (tag_w[t][PI]),
                .next_score (score_w[t][NI]),
                .next_tag   (tag_w[t][NI]),
                .score      (score_w[t][i]),
                .tag        (tag_w[t][i]),
                .gt         (gt_w[t][i]),
                .pos        (pos_w[t][i])
            );
        end
    end

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign ins_ok    = gt_w[req.list_select][TABLE_DEPTH-1];
    assign idx_ok    = 32'(req.rank_index) < TABLE_DEPTH;

    always_comb
    begin
        ins_rank = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (pos_w[req.list_select][i])
            begin
                ins_rank = ins_rank | RANK_W'(i);
            end
        end
    end

    always_comb
    begin
        ctl_w[0]           = '0;
        ctl_w[1]           = '0;
        data_tag           = '0;
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        read_sel_next      = read_sel_reg;
        latest_rank_next   = latest_rank_reg;
        out_valid_next     = out_valid_reg && !rsp.ready;
        out_status_next    = out_status_reg;
        out_rank_next      = out_rank_reg;
        out_score_next     = out_score_reg;
        out_tag_next       = out_tag_reg;
        out_last_rank_next = out_last_rank_reg;
        out_last_next      = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_score_next = '0;
                    out_tag_next   = '0;
                    out_last_next  = 1'b1;
                    out_status_next = STATUS_DONE;
                    out_rank_next   = '0;
                    unique case (req_type_t'(req.req_type))
                        REQ_SUBMIT:
                        begin
                            data_tag = placeholder_tag_reg;
                            ctl_w[req.list_select].insert = 1'b1;
                            if (ins_ok)
                            begin
                                latest_rank_next = LAST_RANK_W'(ins_rank);
                                out_rank_next    = RANK_OUT_W'(ins_rank);
                            end
                            else
                            begin
                                latest_rank_next = '1;
                                out_status_next  = STATUS_LOW_SCORE;
                            end
                            out_valid_next = 1'b1;
                        end
                        REQ_RENAME:
                        begin
                            data_tag = req.name_tag;
                            ctl_w[req.list_select].rename = 1'b1;
                            if (idx_ok)
                            begin
                                out_rank_next = req.rank_index;
                            end
                            else
                            begin
                                out_status_next = STATUS_BAD_INDEX;
                            end
                            out_valid_next = 1'b1;
                        end
                        REQ_READ:
                        begin
                            state_next    = ST_READ;
                            cnt_next      = '0;
                            read_sel_next = req.list_select;
                        end
                        REQ_CLEAR:
                        begin
                            data_tag = empty_tag_reg;
                            ctl_w[req.list_select].clear = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                    out_last_rank_next = latest_rank_next;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    // emit cell 0 and rotate the table one place toward it
                    ctl_w[read_sel_reg].rotate = 1'b1;
                    out_valid_next     = 1'b1;
                    out_status_next    = STATUS_DONE;
                    out_rank_next      = RANK_OUT_W'(cnt_reg);
                    out_score_next     = score_w[read_sel_reg][0];
                    out_tag_next       = tag_w[read_sel_reg][0];
                    out_last_rank_next = latest_rank_reg;
                    out_last_next      = 32'(cnt_reg) == TABLE_DEPTH - 1;
                    cnt_next           = cnt_reg + 1'b1;
                    if (32'(cnt_reg) == TABLE_DEPTH - 1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            placeholder_tag_reg <= PLACEHOLDER_TAG_RESET[TAG_BITS-1:0];
            empty_tag_reg       <= EMPTY_TAG_RESET[TAG_BITS-1:0];
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PLACEHOLDER_TAG: placeholder_tag_reg <= cfg_data;
                CFG_EMPTY_TAG:       empty_tag_reg       <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            read_sel_reg    <= 1'b0;
            latest_rank_reg <= '1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            read_sel_reg    <= read_sel_next;
            latest_rank_reg <= latest_rank_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg    <= out_status_next;
        out_rank_reg      <= out_rank_next;
        out_score_reg     <= out_score_next;
        out_tag_reg       <= out_tag_next;
        out_last_rank_reg <= out_last_rank_next;
        out_last_reg      <= out_last_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.entry_rank    = out_rank_reg;
    assign rsp.entry_score   = out_score_reg;
    assign rsp.entry_tag     = out_tag_reg;
    assign rsp.last_new_rank = out_last_rank_reg;
    assign rsp.last_of_run   = out_last_reg;

    `TTS_ASSERT_IMP(a_dyn_sorted, state_reg == ST_IDLE, $onehot0(pos_w[0]))
    `TTS_ASSERT_IMP(a_fix_sorted, state_reg == ST_IDLE, $onehot0(pos_w[1]))
    `TTS_ASSERT_IMP(a_partial_from_read, rsp.valid && !rsp.last_of_run, state_reg == ST_READ)
    `TTS_ASSERT_NEXT(a_read_start, accept && (req.req_type == REQ_READ), (state_reg == ST_READ) && (cnt_reg == '0))

endmodule

### sv/tts_cell.sv
`timescale 1ns / 1ps
module tts_cell #(
    parameter int TAG_BITS = tts_pkg::TAG_BITS_DEFAULT,
    parameter int IDX      = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tts_pkg::cell_ctl_t          ctl,
    input  logic [tts_pkg::SCORE_W-1:0] new_score,
    input  logic [tts_pkg::IDX_W-1:0]   rank_index,
    input  logic [TAG_BITS-1:0]         data_tag,
    input  logic                        prev_gt,
    input  logic [tts_pkg::SCORE_W-1:0] prev_score,
    input  logic [TAG_BITS-1:0]         prev_tag,
    input  logic [tts_pkg::SCORE_W-1:0] next_score,
    input  logic [TAG_BITS-1:0]         next_tag,
    output logic [tts_pkg::SCORE_W-1:0] score,
    output logic [TAG_BITS-1:0]         tag,
    output logic                        gt,
    output logic                        pos
);
    import tts_pkg::*;

    logic [SCORE_W-1:0]  score_reg, score_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;

    assign gt    = new_score > score_reg;
    assign pos   = gt && !prev_gt;
    assign score = score_reg;
    assign tag   = tag_reg;

    always_comb
    begin
        score_next = score_reg;
        tag_next   = tag_reg;
        if (ctl.insert && gt)
        begin
            // shift down from above, or take the new entry at the insertion point
            if (prev_gt)
            begin
                score_next = prev_score;
                tag_next   = prev_tag;
            end
            else
            begin
                score_next = new_score;
                tag_next   = data_tag;
            end
        end
        else if (ctl.rename && (32'(rank_index) == IDX))
        begin
            tag_next = data_tag;
        end
        else if (ctl.clear)
        begin
            score_next = '0;
            tag_next   = data_tag;
        end
        else if (ctl.rotate)
        begin
            score_next = next_score;
            tag_next   = next_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg <= '0;
            tag_reg   <= EMPTY_TAG_RESET[TAG_BITS-1:0];
        end
        else
        begin
            score_reg <= score_next;
            tag_reg   <= tag_next;
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import tts_pkg::*;

    localparam int DEPTH     = DEPTH_DEFAULT;
    localparam int TAGW      = TAG_BITS_DEFAULT;
    localparam int HOLD_LEN  = 200;
    localparam int WDOG_MAX  = 3000;
    localparam int DRAIN_GAP = 30;

    typedef struct {
        req_type_t   kind;
        logic        lsel;
        logic [7:0]  score;
        logic [3:0]  idx;
        logic [63:0] tag;
    } score_req_t;

    typedef struct {
        status_t            status;
        logic [3:0]         rank;
        logic [7:0]         score;
        logic [63:0]        tag;
        logic signed [4:0]  last_rank;
        logic               last;
    } score_rsp_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [TAGW-1:0] cfg_data;

    tts_req_if #(.TAG_BITS(TAGW)) req_if ();
    tts_rsp_if #(.TAG_BITS(TAGW)) rsp_if ();

    top_ten_score_table #(
        .TABLE_DEPTH(DEPTH),
        .TAG_BITS(TAGW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_if),
        .rsp(rsp_if),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic [7:0]        board_score [2][DEPTH];
    logic [63:0]       board_tag   [2][DEPTH];
    logic signed [4:0] latest_rank;
    logic [63:0]       mdl_placeholder;
    logic [63:0]       mdl_empty;

    score_req_t pending_reqs[$];
    score_rsp_t expected_reports[$];

    int  fail_count;
    int  gap_left;
    int  stall_left;
    int  hold_left;
    int  hold_seq;
    int  hold_seen;
    int  quiet_cycles;
    bit  no_idle;

    function automatic void clear_board(input int t);
        int i;
        for (i = 0; i < DEPTH; i++)
        begin
            board_score[t][i] = 8'd0;
            board_tag[t][i]   = mdl_empty;
        end
    endfunction

    function automatic void apply_request(input score_req_t r);
        int t;
        int pos;
        int i;
        score_rsp_t e;
        t = r.lsel ? 1 : 0;
        e.status    = STATUS_DONE;
        e.rank      = 4'd0;
        e.score     = 8'd0;
        e.tag       = 64'd0;
        e.last      = 1'b1;
        case (r.kind)
            REQ_SUBMIT:
            begin
                if (r.score <= board_score[t][DEPTH-1])
                begin
                    latest_rank = -5'sd1;
                    e.status = STATUS_LOW_SCORE;
                end
                else
                begin
                    pos = DEPTH - 1;
                    for (i = DEPTH - 1; i >= 0; i--)
                        if (r.score > board_score[t][i])
                            pos = i;
                    for (i = DEPTH - 1; i > pos; i--)
                    begin
                        board_score[t][i] = board_score[t][i-1];
                        board_tag[t][i]   = board_tag[t][i-1];
                    end
                    board_score[t][pos] = r.score;
                    board_tag[t][pos]   = mdl_placeholder;
                    latest_rank = 5'(pos);
                    e.rank = 4'(pos);
                end
                e.last_rank = latest_rank;
                expected_reports.push_back(e);
            end
            REQ_RENAME:
            begin
                if (r.idx >= DEPTH)
                    e.status = STATUS_BAD_INDEX;
                else
                begin
                    board_tag[t][r.idx] = r.tag;
                    e.rank = r.idx;
                end
                e.last_rank = latest_rank;
                expected_reports.push_back(e);
            end
            REQ_READ:
            begin
                for (i = 0; i < DEPTH; i++)
                begin
                    e.rank      = 4'(i);
                    e.score     = board_score[t][i];
                    e.tag       = board_tag[t][i];
                    e.last      = (i == DEPTH - 1);
                    e.last_rank = latest_rank;
                    expected_reports.push_back(e);
                end
            end
            default:
            begin
                clear_board(t);
                e.last_rank = latest_rank;
                expected_reports.push_back(e);
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    function automatic score_req_t random_request();
        score_req_t r;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            r.kind = REQ_SUBMIT;
        else if (roll < 72)
            r.kind = REQ_RENAME;
        else if (roll < 93)
            r.kind = REQ_READ;
        else
            r.kind = REQ_CLEAR;
        r.lsel  = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
            r.score = 8'($urandom_range(0, 12));
        else
            r.score = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0)
            r.idx = 4'($urandom_range(10, 15));
        else
            r.idx = 4'($urandom_range(0, 9));
        r.tag = {$urandom, $urandom};
        return r;
    endfunction

    task automatic push_req(input req_type_t kind, input logic lsel, input logic [7:0] score,
                            input logic [3:0] idx, input logic [63:0] tag);
        score_req_t r;
        r.kind  = kind;
        r.lsel  = lsel;
        r.score = score;
        r.idx   = idx;
        r.tag   = tag;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PLACEHOLDER_TAG)
            mdl_placeholder = val;
        else
            mdl_empty = val;
    endtask

    task automatic random_phase(input int n, input bit squeeze);
        int i;
        for (i = 0; i < n; i++)
            pending_reqs.push_back(random_request());
        if (squeeze)
            hold_seq++;
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: hold an item until it is taken, idle in random bursts between items unless no_idle is set.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            gap_left     <= 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                apply_request(pending_reqs[0]);
                void'(pending_reqs.pop_front());
            end
            if (req_if.valid && !req_if.ready)
                req_if.valid <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left     <= gap_left - 1;
                req_if.valid <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                gap_left     <= $urandom_range(0, 9);
                req_if.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                req_if.valid       <= 1'b1;
                req_if.req_type    <= pending_reqs[0].kind;
                req_if.list_select <= pending_reqs[0].lsel;
                req_if.new_score   <= pending_reqs[0].score;
                req_if.rank_index  <= pending_reqs[0].idx;
                req_if.name_tag    <= pending_reqs[0].tag;
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
            hold_seen    <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end
        else if (hold_seen != hold_seq)
        begin
            hold_seen    <= hold_seq;
            hold_left    <= HOLD_LEN;
            rsp_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            stall_left   <= $urandom_range(0, 9);
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= 1'b1;
    end

    // Monitor: compare each item taken from the output with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_reports.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected item, expected none actual status %0h rank %0h",
                         $time, rsp_if.status, rsp_if.entry_rank);
            end
            else
            begin
                check_field("status", expected_reports[0].status, rsp_if.status);
                check_field("entry_rank", expected_reports[0].rank, rsp_if.entry_rank);
                check_field("entry_score", expected_reports[0].score, rsp_if.entry_score);
                check_field("entry_tag", expected_reports[0].tag, rsp_if.entry_tag);
                check_field("last_new_rank", expected_reports[0].last_rank,
                            rsp_if.last_new_rank);
                check_field("last_of_run", expected_reports[0].last, rsp_if.last_of_run);
                void'(expected_reports.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else if (pending_reqs.size() != 0 || expected_reports.size() != 0)
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_MAX)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_PLACEHOLDER_TAG;
        cfg_data           = '0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_SUBMIT;
        req_if.list_select = 1'b0;
        req_if.new_score   = '0;
        req_if.rank_index  = '0;
        req_if.name_tag    = '0;
        rsp_if.ready       = 1'b0;
        fail_count         = 0;
        hold_seq           = 0;
        quiet_cycles       = 0;
        no_idle            = 1'b0;
        mdl_placeholder    = PLACEHOLDER_TAG_RESET;
        mdl_empty          = EMPTY_TAG_RESET;
        latest_rank        = -5'sd1;
        clear_board(0);
        clear_board(1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        push_req(REQ_READ,   1'b0, 8'd0,   4'd0,  64'd0);
        push_req(REQ_READ,   1'b1, 8'd0,   4'd0,  64'd0);
        push_req(REQ_SUBMIT, 1'b0, 8'd0,   4'd0,  64'd0);
        push_req(REQ_SUBMIT, 1'b1, 8'd255, 4'd0,  64'd0);
        push_req(REQ_SUBMIT, 1'b1, 8'd255, 4'd0,  64'd0);
        push_req(REQ_SUBMIT, 1'b1, 8'd1,   4'd0,  64'd0);
        push_req(REQ_SUBMIT, 1'b1, 8'd128, 4'd0,  64'd0);
        push_req(REQ_RENAME, 1'b1, 8'd0,   4'd0,  {64{1'b1}});
        push_req(REQ_RENAME, 1'b1, 8'd0,   4'd9,  64'd0);
        push_req(REQ_RENAME, 1'b1, 8'd0,   4'd10, 64'h1234_5678_9ABC_DEF0);
        push_req(REQ_RENAME, 1'b0, 8'd255, 4'd15, {64{1'b1}});
        push_req(REQ_READ,   1'b1, 8'd0,   4'd0,  64'd0);
        push_req(REQ_CLEAR,  1'b1, 8'd0,   4'd0,  64'd0);
        push_req(REQ_READ,   1'b1, 8'd0,   4'd0,  64'd0);
        push_req(REQ_SUBMIT, 1'b0, 8'd255, 4'd0,  64'd0);
        push_req(REQ_RENAME, 1'b0, 8'd0,   4'd0,  64'h5555_5555_5555_5555);
        push_req(REQ_READ,   1'b0, 8'd0,   4'd0,  64'd0);
        push_req(REQ_CLEAR,  1'b0, 8'd0,   4'd0,  64'd0);
        push_req(REQ_SUBMIT, 1'b1, 8'd0,   4'd0,  64'd0);
        push_req(REQ_READ,   1'b1, 8'd0,   4'd0,  64'd0);
        wait_drained();

        write_reg(CFG_PLACEHOLDER_TAG, {64{1'b1}});
        write_reg(CFG_EMPTY_TAG, 64'd0);
        random_phase(50, 1'b0);

        write_reg(CFG_PLACEHOLDER_TAG, 64'd0);
        write_reg(CFG_EMPTY_TAG, {64{1'b1}});
        random_phase(50, 1'b1);

        write_reg(CFG_PLACEHOLDER_TAG, {$urandom, $urandom});
        write_reg(CFG_EMPTY_TAG, {$urandom, $urandom});
        random_phase(70, 1'b0);

        write_reg(CFG_PLACEHOLDER_TAG, {$urandom, $urandom});
        write_reg(CFG_EMPTY_TAG, EMPTY_TAG_RESET);
        random_phase(60, 1'b0);

        no_idle = 1'b1;
        random_phase(60, 1'b0);

        repeat (DRAIN_GAP) @(posedge clk);
        if (fail_count == 0 && expected_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
